// ===== rtl/kmer_window_matcher_defines.svh =====
// Assertion macros for the k-mer window matcher.
`ifndef KMER_WINDOW_MATCHER_DEFINES_SVH
`define KMER_WINDOW_MATCHER_DEFINES_SVH

`ifndef SYNTHESIS
`define KWM_ASSERT_SAME(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("kmer_window_matcher: same-cycle check failed");
`define KWM_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("kmer_window_matcher: next-cycle check failed");
`else
`define KWM_ASSERT_SAME(label, clk, rst_n, cond, prop)
`define KWM_ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif

`endif

// ===== rtl/kwm_pkg.sv =====
package kwm_pkg;

    // Default sizing
    localparam int MAX_K_DEF       = 32;
    localparam int INDEX_WIDTH_DEF = 32;

    // Fixed field widths
    localparam int CODE_W   = 4;
    localparam int KLEN_W   = 6;
    localparam int TARGET_W = 64;
    localparam int POS_W    = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 64;

    // Saturation point of the valid-base count
    localparam logic [KLEN_W-1:0] CNT_MAX = '1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_KMER    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KMER_LENGTH    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CANONICAL_MODE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_ONLY     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_START_INDEX    = 3'd4;

    // Per-beat control shared by the window and tracking stages
    typedef struct packed {
        logic step;   // input register advances into the result register
        logic first;  // beat opens a new range
    } t_ctl;

endpackage

// ===== rtl/kwm_window.sv =====
module kwm_window #(
    parameter int MAX_K = kwm_pkg::MAX_K_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  kwm_pkg::t_ctl                      i_ctl,
    input  logic [kwm_pkg::CODE_W-1:0]         i_code,
    input  logic                               i_stopped,
    input  logic [2*MAX_K-1:0]                 i_mask,
    input  logic [$clog2(2*MAX_K)-1:0]         i_rev_shift,
    input  logic [kwm_pkg::KLEN_W-1:0]         i_k,
    input  logic                               i_canonical,
    input  logic [kwm_pkg::TARGET_W-1:0]       i_target,
    output logic                               o_hit
);
    import kwm_pkg::*;

    localparam int W  = 2 * MAX_K;

    logic [W-1:0]      r_fwd, r_rev;
    logic [KLEN_W-1:0] r_cnt;
    logic [W-1:0]      n_fwd, n_rev;
    logic [KLEN_W-1:0] n_cnt;

    logic [W-1:0]      fwd_cur, rev_cur, fwd_shift, rev_shift, sel;
    logic [KLEN_W-1:0] cnt_cur, cnt_inc;
    logic              code_ok;

    // Roll both windows by one base and compare the selected k-mer
    always_comb begin
        fwd_cur   = i_ctl.first ? '0 : r_fwd;
        rev_cur   = i_ctl.first ? '0 : r_rev;
        cnt_cur   = i_ctl.first ? '0 : r_cnt;
        code_ok   = (i_code[3:2] == 2'b00);
        fwd_shift = ((fwd_cur << 2) | W'(i_code[1:0])) & i_mask;
        rev_shift = ((rev_cur >> 2) | (W'(~i_code[1:0]) << i_rev_shift)) & i_mask;
        cnt_inc   = (cnt_cur == CNT_MAX) ? cnt_cur : cnt_cur + 1'b1;
        sel       = (i_canonical && (rev_shift < fwd_shift)) ? rev_shift : fwd_shift;
        o_hit     = !i_stopped && code_ok && (cnt_inc >= i_k) &&
                    (TARGET_W'(sel) == i_target);

        // Frozen once stopped; an N base clears the run
        if (i_stopped) begin
            n_fwd = fwd_cur;
            n_rev = rev_cur;
            n_cnt = cnt_cur;
        end else if (code_ok) begin
            n_fwd = fwd_shift;
            n_rev = rev_shift;
            n_cnt = cnt_inc;
        end else begin
            n_fwd = '0;
            n_rev = '0;
            n_cnt = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= '0;
            r_rev <= '0;
            r_cnt <= '0;
        end else if (i_ctl.step) begin
            r_fwd <= n_fwd;
            r_rev <= n_rev;
            r_cnt <= n_cnt;
        end
    end

endmodule

// ===== rtl/kwm_track.sv =====
module kwm_track #(
    parameter int INDEX_WIDTH = kwm_pkg::INDEX_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  kwm_pkg::t_ctl                   i_ctl,
    input  logic                            i_last,
    input  logic                            i_hit,
    input  logic [kwm_pkg::KLEN_W-1:0]      i_k,
    input  logic                            i_first_only,
    input  logic [kwm_pkg::POS_W-1:0]       i_start_index,
    input  logic                            i_out_ready,
    output logic                            o_stopped,
    output logic                            o_out_valid,
    output logic                            o_window_hit,
    output logic [kwm_pkg::POS_W-1:0]       o_hit_start,
    output logic                            o_found,
    output logic [kwm_pkg::POS_W-1:0]       o_found_start,
    output logic                            o_done_res
);
    import kwm_pkg::*;

    logic [INDEX_WIDTH-1:0] r_pos, n_pos, pos_cur, hstart;
    logic                   r_found, n_found;
    logic [POS_W-1:0]       r_found_pos, n_found_pos;
    logic                   r_stopped, n_stopped;

    logic                   r_out_valid;
    logic                   r_hit;
    logic [POS_W-1:0]       r_hit_start;
    logic                   r_found_o;
    logic [POS_W-1:0]       r_found_start_o;
    logic                   r_done;

    // Stop flag seen by the window stage for this beat
    assign o_stopped = i_ctl.first ? 1'b0 : r_stopped;

    // Position, recorded hit and stop flag for this beat
    always_comb begin
        pos_cur     = i_ctl.first ? INDEX_WIDTH'(i_start_index) : r_pos;
        n_found     = i_ctl.first ? 1'b0 : r_found;
        n_found_pos = i_ctl.first ? '0 : r_found_pos;
        n_stopped   = i_ctl.first ? 1'b0 : r_stopped;
        hstart      = pos_cur - INDEX_WIDTH'(i_k) + 1'b1;
        if (i_hit) begin
            n_found     = 1'b1;
            n_found_pos = POS_W'(hstart);
            if (i_first_only) begin
                n_stopped = 1'b1;
            end
        end
        n_pos = pos_cur + 1'b1;
    end

    // Range state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_found     <= 1'b0;
            r_found_pos <= '0;
            r_stopped   <= 1'b0;
        end else if (i_ctl.step) begin
            r_pos       <= n_pos;
            r_found     <= n_found;
            r_found_pos <= n_found_pos;
            r_stopped   <= n_stopped;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.step) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.step) begin
            r_hit           <= i_hit;
            r_hit_start     <= i_hit ? POS_W'(hstart) : '0;
            r_found_o       <= n_found;
            r_found_start_o <= n_found ? n_found_pos : '0;
            r_done          <= i_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_window_hit  = r_hit;
    assign o_hit_start   = r_hit_start;
    assign o_found       = r_found_o;
    assign o_found_start = r_found_start_o;
    assign o_done_res    = r_done;

endmodule

// ===== rtl/kmer_window_matcher.sv =====
// Rolling k-mer matcher: one DNA base per beat, one result beat per input beat.
// Beats pass the input register, then the result register; window roll, compare and
// position update share one stage. One base per cycle unless i_out_ready stalls output.
// Reset (synchronous, active low) clears windows, count, position and recorded hit,
// and returns the registers to k = 1, forward mode, latest-hit mode, start 0.
`include "kmer_window_matcher_defines.svh"

module kmer_window_matcher #(
    parameter int MAX_K       = kwm_pkg::MAX_K_DEF,
    parameter int INDEX_WIDTH = kwm_pkg::INDEX_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [kwm_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [kwm_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // input channel
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [kwm_pkg::CODE_W-1:0]        i_base_code,
    input  logic                              i_first_of_range,
    input  logic                              i_end_of_range,
    // result channel
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_window_hit,
    output logic [kwm_pkg::POS_W-1:0]         o_hit_start,
    output logic                              o_found,
    output logic [kwm_pkg::POS_W-1:0]         o_found_start,
    output logic                              o_done_res
);
    import kwm_pkg::*;

    localparam int W  = 2 * MAX_K;
    localparam int SW = $clog2(W);

    // Configuration registers, k already clamped and its mask precomputed
    logic [TARGET_W-1:0] r_target;
    logic [KLEN_W-1:0]   r_k;
    logic [W-1:0]        r_mask;
    logic [SW-1:0]       r_rev_shift;
    logic                r_canonical;
    logic                r_first_only;
    logic [POS_W-1:0]    r_start_index;

    logic [KLEN_W-1:0]   k_eff;
    logic [W-1:0]        n_mask;

    always_comb begin
        if (i_cfg_data[KLEN_W-1:0] == '0) begin
            k_eff = KLEN_W'(1);
        end else if (i_cfg_data[KLEN_W-1:0] > KLEN_W'(MAX_K)) begin
            k_eff = KLEN_W'(MAX_K);
        end else begin
            k_eff = i_cfg_data[KLEN_W-1:0];
        end
        for (int i = 0; i < W; i++) begin
            n_mask[i] = (i < 2 * int'(k_eff));
        end
    end

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target      <= '0;
            r_k           <= KLEN_W'(1);
            r_mask        <= W'(2'b11);
            r_rev_shift   <= '0;
            r_canonical   <= 1'b0;
            r_first_only  <= 1'b0;
            r_start_index <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_TARGET_KMER: begin
                    r_target <= i_cfg_data[TARGET_W-1:0];
                end
                CFG_KMER_LENGTH: begin
                    r_k         <= k_eff;
                    r_mask      <= n_mask;
                    r_rev_shift <= SW'(2 * (int'(k_eff) - 1));
                end
                CFG_CANONICAL_MODE: begin
                    r_canonical <= i_cfg_data[0];
                end
                CFG_FIRST_ONLY: begin
                    r_first_only <= i_cfg_data[0];
                end
                CFG_START_INDEX: begin
                    r_start_index <= i_cfg_data[POS_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Input register
    logic              r_in_valid;
    logic [CODE_W-1:0] r_code;
    logic              r_first;
    logic              r_last;
    logic              advance;
    t_ctl              ctl;

    assign advance    = r_in_valid && (!o_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;
    assign ctl.step   = advance;
    assign ctl.first  = r_first;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_code  <= i_base_code;
            r_first <= i_first_of_range;
            r_last  <= i_end_of_range;
        end
    end

    logic hit;
    logic stopped;

    kwm_window #(
        .MAX_K (MAX_K)
    ) u_window (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .i_code      (r_code),
        .i_stopped   (stopped),
        .i_mask      (r_mask),
        .i_rev_shift (r_rev_shift),
        .i_k         (r_k),
        .i_canonical (r_canonical),
        .i_target    (r_target),
        .o_hit       (hit)
    );

    kwm_track #(
        .INDEX_WIDTH (INDEX_WIDTH)
    ) u_track (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (ctl),
        .i_last        (r_last),
        .i_hit         (hit),
        .i_k           (r_k),
        .i_first_only  (r_first_only),
        .i_start_index (r_start_index),
        .i_out_ready   (i_out_ready),
        .o_stopped     (stopped),
        .o_out_valid   (o_out_valid),
        .o_window_hit  (o_window_hit),
        .o_hit_start   (o_hit_start),
        .o_found       (o_found),
        .o_found_start (o_found_start),
        .o_done_res    (o_done_res)
    );

    // A hit beat always records itself as the found position
    `KWM_ASSERT_SAME(a_hit_records, i_clk, i_rst_n, o_out_valid && o_window_hit, o_found && (o_found_start == o_hit_start))
    // Empty result fields read as zero
    `KWM_ASSERT_SAME(a_zero_fields, i_clk, i_rst_n, o_out_valid && !o_found, (o_found_start == '0) && !o_window_hit && (o_hit_start == '0))
    // A step always leaves a result waiting in the result register
    `KWM_ASSERT_NEXT(a_step_fills_out, i_clk, i_rst_n, advance, o_out_valid)
    // A held input beat with a stalled result blocks new input
    `KWM_ASSERT_SAME(a_full_blocks, i_clk, i_rst_n, r_in_valid && o_out_valid && !i_out_ready, !o_in_ready)

endmodule
